// ===== src/cfws_pkg.sv =====
// Shared types and constants for the circular FIFO with search.
// Used by cfws_engine and circular_fifo_with_search_top; no dependencies.
`default_nettype none

package cfws_pkg;

	// operation codes carried in func
	localparam logic [2:0] FUNC_ENQ    = 3'd0;
	localparam logic [2:0] FUNC_DEQ    = 3'd1;
	localparam logic [2:0] FUNC_PEEK   = 3'd2;
	localparam logic [2:0] FUNC_SEARCH = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;

	// store entries; count, position and capacity widths are sized for it
	localparam int unsigned DEPTH   = 16;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned CAP_W   = 5;

	// one result of one request
	typedef struct packed {
		logic               status;
		logic [DATA_W-1:0]  data;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] count;
		logic               empty;
		logic               full;
	} res_t;

endpackage

`default_nettype wire

// ===== src/cfws_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module cfws_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/cfws_engine.sv =====
// Queue sequencer: pointers, occupancy and the per-request state machine.
// Drives the store RAM; depends on cfws_pkg.
`default_nettype none

module cfws_engine (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [2:0]                             func,
	input  wire logic [cfws_pkg::DATA_W-1:0]            value,
	input  wire logic [$clog2(cfws_pkg::DEPTH):0]       eff_cap,
	input  wire logic                                   cfg_clear,
	input  wire logic                                   out_free,
	output logic                                        res_valid,
	output cfws_pkg::res_t                              res,
	output logic                                        ram_we,
	output logic      [$clog2(cfws_pkg::DEPTH)-1:0]     ram_waddr,
	output logic      [cfws_pkg::DATA_W-1:0]            ram_wdata,
	output logic      [$clog2(cfws_pkg::DEPTH)-1:0]     ram_raddr,
	input  wire logic [cfws_pkg::DATA_W-1:0]            ram_rdata
);

	import cfws_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned EW = AW + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_HOLD
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      head_q, tail_q, idx_q;
	logic [COUNT_W-1:0] occ_q, i_q;
	logic [2:0]         func_q;
	logic [DATA_W-1:0]  value_q;
	res_t               res_q;

	logic [AW-1:0]      head_n, tail_n;
	logic [COUNT_W-1:0] occ_n;
	logic               done;
	res_t               res_d;
	logic [EW-1:0]      occ_ext, occ_n_ext;

	// ring advance, wrapping at the effective capacity
	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p,
			input logic [EW-1:0] cap);
		logic [EW-1:0] n;
		n = EW'(p) + EW'(1);
		return (n >= cap) ? '0 : n[AW-1:0];
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign occ_ext   = EW'(occ_q);
	assign occ_n_ext = EW'(occ_n);

	assign ram_raddr = (state_q == ST_SEARCH) ? next_idx(idx_q, eff_cap) : head_q;
	assign ram_waddr = tail_q;
	assign ram_wdata = value_q;

	always_comb begin
		done           = 1'b0;
		ram_we         = 1'b0;
		head_n         = head_q;
		tail_n         = tail_q;
		occ_n          = occ_q;
		res_d          = '0;
		res_d.status   = 1'b1;
		unique case (state_q)
			ST_EXEC: begin
				done = 1'b1;
				unique case (func_q)
					FUNC_ENQ: begin
						if (occ_ext < eff_cap) begin
							ram_we       = 1'b1;
							tail_n       = next_idx(tail_q, eff_cap);
							occ_n        = COUNT_W'(occ_q + COUNT_W'(1));
							res_d.status = 1'b0;
						end
					end
					FUNC_DEQ: begin
						if (occ_q != '0) begin
							res_d.data   = ram_rdata;
							head_n       = next_idx(head_q, eff_cap);
							occ_n        = COUNT_W'(occ_q - COUNT_W'(1));
							res_d.status = 1'b0;
						end
					end
					FUNC_PEEK: begin
						if (occ_q != '0) begin
							res_d.data   = ram_rdata;
							res_d.status = 1'b0;
						end
					end
					FUNC_CLEAR: begin
						head_n       = '0;
						tail_n       = '0;
						occ_n        = '0;
						res_d.status = 1'b0;
					end
					default: begin
					end
				endcase
			end
			ST_SEARCH: begin
				// rdata holds the entry at idx_q, i_q places from the head
				if (i_q == occ_q) begin
					done = 1'b1;
				end else if (ram_rdata == value_q) begin
					done           = 1'b1;
					res_d.status   = 1'b0;
					res_d.position = i_q[POS_W-1:0];
				end
			end
			default: begin
			end
		endcase
		res_d.count = occ_n;
		res_d.empty = (occ_n == '0);
		res_d.full  = (occ_n_ext == eff_cap);
	end

	assign res_valid = done || (state_q == ST_HOLD);
	assign res       = (state_q == ST_HOLD) ? res_q : res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
		end else if (cfg_clear) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (func == FUNC_SEARCH) ? ST_SEARCH : ST_EXEC;
					end
				end
				ST_EXEC, ST_SEARCH: begin
					if (done) begin
						head_q  <= head_n;
						tail_q  <= tail_n;
						occ_q   <= occ_n;
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q  <= func;
			value_q <= value;
			idx_q   <= head_q;
			i_q     <= '0;
		end else if (state_q == ST_SEARCH && !done) begin
			idx_q <= next_idx(idx_q, eff_cap);
			i_q   <= COUNT_W'(i_q + COUNT_W'(1));
		end
		if (done) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/circular_fifo_with_search_top.sv =====
// Top level of the circular FIFO with search: capacity register, result register,
// sequencer and store RAM. Depends on cfws_pkg, cfws_engine and cfws_ram.
`default_nettype none

// Ring-buffer queue of 32-bit words held in one synchronous RAM of DEPTH
// entries. Each request is one operation (enqueue, dequeue, peek, search,
// clear). Enqueue, dequeue, peek, clear and unknown codes are carried out in
// the sequencer's execute state, which then returns to idle for the next
// request; a search reads one entry per cycle through the single RAM read
// port, from the head until a hit or until count entries are read, and
// returns to idle only after that. Each result is registered in the output
// register before it shows. Requests are taken one at a time; a new one is
// accepted while the previous result still waits in the output register, and
// a second finished result stalls the input until the output drains. Writing
// capacity (0 acts as 1, above DEPTH acts as DEPTH) empties the queue; the RAM
// keeps its words and needs no clearing after reset.
module circular_fifo_with_search_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [2:0]                            func,
	input  wire logic signed [cfws_pkg::DATA_W-1:0]    value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       status,
	output logic signed [cfws_pkg::DATA_W-1:0]         data,
	output logic        [cfws_pkg::POS_W-1:0]          position,
	output logic        [cfws_pkg::COUNT_W-1:0]        count,
	output logic                                       empty_res,
	output logic                                       full_res,
	input  wire logic                                  cfg_we,
	input  wire logic   [cfws_pkg::CAP_W-1:0]          cfg_wdata
);

	import cfws_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned EW = AW + 1;
	localparam int unsigned XW = (EW > CAP_W) ? EW : CAP_W;

	logic [CAP_W-1:0]  cap_q;
	logic [XW-1:0]     cap_ext;
	logic [EW-1:0]     eff_cap;
	logic              out_valid_q;
	res_t              out_q;
	logic              out_free;
	logic              res_valid;
	res_t              res;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	assign cap_ext = XW'(cap_q);
	assign eff_cap = (cap_q == '0)            ? EW'(1) :
	                 (cap_ext > XW'(DEPTH))   ? EW'(DEPTH) : EW'(cap_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(16);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign data      = out_q.data;
	assign position  = out_q.position;
	assign count     = out_q.count;
	assign empty_res = out_q.empty;
	assign full_res  = out_q.full;

	cfws_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.eff_cap   (eff_cap),
		.cfg_clear (cfg_we),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	cfws_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire
